// ===== design/gyro_bias_complementary_filter_assert.svh =====
// Assertion macros for the gyro bias complementary filter.
`ifndef GYRO_BIAS_COMPLEMENTARY_FILTER_ASSERT_SVH
`define GYRO_BIAS_COMPLEMENTARY_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define GBCF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gbcf: check failed");

// next-cycle implication
`define GBCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gbcf: check failed");

`else

`define GBCF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GBCF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/gbcf_pkg.sv =====
`timescale 1ns / 1ps

package gbcf_pkg;

    localparam int CHANNELS = 2;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // one channel's state as stored in the state memory
    typedef struct packed {
        logic               seen;
        logic signed [15:0] prev_rate;
        logic signed [15:0] bias;
        logic signed [31:0] acc;
        logic signed [31:0] last_error;
    } gbcf_entry_t;

    // write-back from the pipeline tail
    typedef struct packed {
        logic            we;
        logic [CH_W-1:0] addr;
        gbcf_entry_t     entry;
    } gbcf_wb_t;

    // pipeline status toward the input side
    typedef struct packed {
        logic                can_take;
        logic [CHANNELS-1:0] busy;
    } gbcf_status_t;

endpackage

// ===== design/gbcf_ram.sv =====
`timescale 1ns / 1ps

module gbcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/gbcf_core.sv =====
`timescale 1ns / 1ps

module gbcf_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      take,
    input  logic [gbcf_pkg::CH_W-1:0] take_ch,
    input  logic                      take_hit,
    input  logic signed [15:0]        take_ref,
    input  logic signed [15:0]        take_rate,
    input  gbcf_pkg::gbcf_entry_t     rd_entry,
    output gbcf_pkg::gbcf_status_t    status,
    output gbcf_pkg::gbcf_wb_t        wb,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [15:0]        m_angle_estimate
);

    import gbcf_pkg::*;

    localparam int NSTAGE     = 9;
    localparam int Q_SHIFT    = 14;
    localparam int RATE_SHIFT = 5;       // rate gain of 32
    localparam int CORR_SHIFT = 8;       // correction by error / 256
    // error*512/1e6 == error*8/15625
    localparam int BIAS_SHIFT = 3;
    localparam int DIVISOR    = 15625;
    localparam int RECIP_SH   = 45;
    localparam logic [31:0] RECIP_M = 32'd2251799813; // floor(2^45 / 15625)
    localparam int QUOT_W     = 18;
    localparam int REM_W      = 15;
    localparam int DELTA_W    = QUOT_W + BIAS_SHIFT + 1;
    localparam logic signed [31:0] Q_ROUND    = 32'((1 << Q_SHIFT) - 1);
    localparam logic signed [31:0] CORR_ROUND = 32'((1 << CORR_SHIFT) - 1);

    typedef struct packed {
        logic [CH_W-1:0]           ch;
        logic                      hit;
        logic signed [15:0]        ref_angle;
        logic signed [15:0]        rate;
        logic                      seen;
        logic signed [15:0]        bias;
        logic signed [31:0]        acc;
        logic signed [31:0]        err;
        logic [31:0]               mag;
        logic                      neg;
        logic [QUOT_W-1:0]         quot;
        logic [REM_W-1:0]          rem;
        logic signed [DELTA_W-1:0] delta;
        logic signed [31:0]        nb_sum;
    } stage_t;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -33'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    stage_t             st_reg  [1:NSTAGE];
    stage_t             st_next [1:NSTAGE];
    logic [1:NSTAGE]    v_reg;
    logic [1:NSTAGE]    v_next;
    logic [1:NSTAGE]    en;
    logic               en_out;
    logic               o_valid_reg;
    logic signed [15:0] o_angle_reg;
    logic signed [15:0] o_angle_next;
    logic signed [15:0] wb_bias;

    // stall chain: a stage moves when the one after it is empty or moving
    always_comb begin
        en_out     = !o_valid_reg || m_ready;
        en[NSTAGE] = !v_reg[NSTAGE] || en_out;
        for (int k = NSTAGE - 1; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[1] = take;
        for (int k = 2; k <= NSTAGE; k++) begin
            v_next[k] = v_reg[k-1];
        end
    end

    always_comb begin
        gbcf_entry_t               e;
        logic signed [16:0]        s1_diff;
        logic signed [32:0]        s1_sum;
        logic signed [32:0]        s2_diff;
        logic signed [31:0]        s3_corr;
        logic signed [32:0]        s3_acc;
        logic [63:0]               s4_prod;
        logic [31:0]               s5_prod;
        logic [31:0]               s5_rem;
        logic [2:0]                s7_frac;
        logic [QUOT_W+BIAS_SHIFT-1:0] s7_mag;
        logic signed [DELTA_W-1:0] s7_pos;
        logic signed [31:0]        s9_nb;
        logic signed [31:0]        s9_ang;

        // stage 1 capture
        st_next[1]           = '0;
        st_next[1].ch        = take_ch;
        st_next[1].hit       = take_hit;
        st_next[1].ref_angle = take_ref;
        st_next[1].rate      = take_rate;

        // stage 1: memory data, integrate the previous rate
        e       = st_reg[1].hit ? rd_entry : '0;
        s1_diff = 17'(e.prev_rate) - 17'(e.bias);
        s1_sum  = 33'(e.acc) + (33'(s1_diff) <<< RATE_SHIFT);
        st_next[2]      = st_reg[1];
        st_next[2].seen = e.seen;
        st_next[2].bias = e.bias;
        st_next[2].err  = e.last_error;
        st_next[2].acc  = sat32(s1_sum);

        // stage 2: new error once the channel has a history
        s2_diff    = 33'(st_reg[2].acc) - (33'(st_reg[2].ref_angle) <<< Q_SHIFT);
        st_next[3] = st_reg[2];
        if (st_reg[2].seen) begin
            st_next[3].err = sat32(s2_diff);
        end

        // stage 3: correction toward the reference, error magnitude
        if (st_reg[3].err[31]) begin
            s3_corr = (st_reg[3].err + CORR_ROUND) >>> CORR_SHIFT;
        end else begin
            s3_corr = st_reg[3].err >>> CORR_SHIFT;
        end
        s3_acc         = 33'(st_reg[3].acc) - 33'(s3_corr);
        st_next[4]     = st_reg[3];
        st_next[4].acc = sat32(s3_acc);
        st_next[4].neg = st_reg[3].err[31];
        st_next[4].mag = st_reg[3].err[31] ? (~st_reg[3].err + 32'd1) : st_reg[3].err;

        // stage 4: quotient estimate by reciprocal, low by at most one
        s4_prod         = st_reg[4].mag * RECIP_M;
        st_next[5]      = st_reg[4];
        st_next[5].quot = s4_prod[RECIP_SH+QUOT_W-1:RECIP_SH];

        // stage 5: remainder of the estimate
        s5_prod        = 32'(st_reg[5].quot) * 32'(DIVISOR);
        s5_rem         = st_reg[5].mag - s5_prod;
        st_next[6]     = st_reg[5];
        st_next[6].rem = s5_rem[REM_W-1:0];

        // stage 6: fix the estimate
        st_next[7] = st_reg[6];
        if (st_reg[6].rem >= REM_W'(DIVISOR)) begin
            st_next[7].quot = st_reg[6].quot + QUOT_W'(1);
            st_next[7].rem  = st_reg[6].rem - REM_W'(DIVISOR);
        end

        // stage 7: the three fraction bits from the remainder, signed delta
        s7_frac = '0;
        for (int k = 1; k < (1 << BIAS_SHIFT); k++) begin
            if ({st_reg[7].rem, BIAS_SHIFT'(0)} >= (REM_W + BIAS_SHIFT)'(DIVISOR * k)) begin
                s7_frac = 3'(k);
            end
        end
        s7_mag           = {st_reg[7].quot, s7_frac};
        s7_pos           = DELTA_W'(s7_mag);
        st_next[8]       = st_reg[7];
        st_next[8].delta = st_reg[7].neg ? -s7_pos : s7_pos;

        // stage 8: bias in Q14 plus delta
        st_next[9]        = st_reg[8];
        st_next[9].nb_sum = (32'(st_reg[8].bias) <<< Q_SHIFT) + 32'(st_reg[8].delta);

        // stage 9: back to integer bias and angle, both toward zero
        if (st_reg[9].nb_sum[31]) begin
            s9_nb = (st_reg[9].nb_sum + Q_ROUND) >>> Q_SHIFT;
        end else begin
            s9_nb = st_reg[9].nb_sum >>> Q_SHIFT;
        end
        if (st_reg[9].acc[31]) begin
            s9_ang = (st_reg[9].acc + Q_ROUND) >>> Q_SHIFT;
        end else begin
            s9_ang = st_reg[9].acc >>> Q_SHIFT;
        end
        wb_bias      = sat16(s9_nb);
        o_angle_next = sat16(s9_ang);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            o_valid_reg <= 1'b0;
        end else begin
            for (int k = 1; k <= NSTAGE; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_next[k];
                end
            end
            if (en_out) begin
                o_valid_reg <= v_reg[NSTAGE];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 1; k <= NSTAGE; k++) begin
            if (en[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
        if (en_out) begin
            o_angle_reg <= o_angle_next;
        end
    end

    always_comb begin
        status.can_take = en[1];
        status.busy     = '0;
        for (int k = 1; k <= NSTAGE; k++) begin
            if (v_reg[k]) begin
                status.busy[st_reg[k].ch] = 1'b1;
            end
        end
    end

    always_comb begin
        wb.we               = v_reg[NSTAGE] && en_out;
        wb.addr             = st_reg[NSTAGE].ch;
        wb.entry.seen       = 1'b1;
        wb.entry.prev_rate  = st_reg[NSTAGE].rate;
        wb.entry.bias       = wb_bias;
        wb.entry.acc        = st_reg[NSTAGE].acc;
        wb.entry.last_error = st_reg[NSTAGE].err;
    end

    assign m_valid          = o_valid_reg;
    assign m_angle_estimate = o_angle_reg;

endmodule

// ===== design/gyro_bias_complementary_filter.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_kind, s_reference_angle, s_rate_sample
// m_        out        m_valid / m_ready   m_angle_estimate
//
// Each channel has at most one item in flight: an item waits until its channel's state is
// written back, so two channels interleaved keep at best two items in flight at once.
// From the accepting edge an item passes the stage 1 register (which takes the memory
// read), eight more stages and the output register before m_valid rises.
// One channel alone takes no new item until the last one is written back: the
// read-modify-write loop through the state memory (accept to write-back) sets that limit.
// Reset clears the per-channel valid bits at once; an unwritten channel reads as zero.
// A stalled m_ side holds the pipeline stage by stage; bubbles still close up.

module gyro_bias_complementary_filter (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic signed [15:0]        s_reference_angle,
    input  logic signed [15:0]        s_rate_sample,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [15:0]        m_angle_estimate
);

    import gbcf_pkg::*;

`include "gyro_bias_complementary_filter_assert.svh"

    localparam int ENTRY_W = $bits(gbcf_entry_t);

    logic [CH_W-1:0]     ch_sel;
    logic                accept;
    logic [CHANNELS-1:0] vld_reg;
    logic [CHANNELS-1:0] vld_next;
    logic [ENTRY_W-1:0]  ram_rdata;
    gbcf_entry_t         rd_entry;
    gbcf_status_t        status;
    gbcf_wb_t            wb;

    // channel codes past the last channel fold onto the last one
    always_comb begin
        if (32'(s_kind) >= CHANNELS) begin
            ch_sel = CH_W'(CHANNELS - 1);
        end else begin
            ch_sel = CH_W'(s_kind);
        end
    end

    // hold an item whose channel is still in flight: its state is not written back yet
    assign s_ready = status.can_take && !status.busy[ch_sel];
    assign accept  = s_valid && s_ready;

    // valid bit per channel stands in for the zero reset of the state memory
    always_comb begin
        vld_next = vld_reg;
        if (wb.we) begin
            vld_next[wb.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // per-channel state: one entry per channel, read on accept, written at the tail
    gbcf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (aclk),
        .we    (wb.we),
        .waddr (wb.addr),
        .wdata (wb.entry),
        .re    (accept),
        .raddr (ch_sel),
        .rdata (ram_rdata)
    );

    assign rd_entry = gbcf_entry_t'(ram_rdata);

    gbcf_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .take             (accept),
        .take_ch          (ch_sel),
        .take_hit         (vld_reg[ch_sel]),
        .take_ref         (s_reference_angle),
        .take_rate        (s_rate_sample),
        .rd_entry         (rd_entry),
        .status           (status),
        .wb               (wb),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_angle_estimate (m_angle_estimate)
    );

    // a read never meets a write of the same entry
    `GBCF_ASSERT_SAME(a_no_rw_overlap, aclk, aresetn, accept && wb.we, wb.addr != ch_sel)
    // an accepted item marks its channel busy until write-back
    `GBCF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, aresetn && accept, status.busy[$past(ch_sel)])
    // a write-back leaves the channel valid
    `GBCF_ASSERT_NEXT(a_valid_after_wb, aclk, aresetn, aresetn && wb.we, vld_reg[$past(wb.addr)])

endmodule

// ===== bench/gbcf_angle_checker.sv =====
`timescale 1ns / 1ps

module gbcf_angle_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_kind,
    input  logic signed [15:0] s_reference_angle,
    input  logic signed [15:0] s_rate_sample,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_angle_estimate,
    output int                 mismatches,
    output int                 pending,
    output int                 checked
);

    import gbcf_pkg::*;

    localparam longint Q_ONE     = longint'(1) <<< 14;
    localparam longint RATE_GAIN = 32;
    localparam longint CORR_DIV  = 256;
    localparam longint BIAS_NUM  = 512;
    localparam longint BIAS_DEN  = 1000000;
    localparam longint I32_MAX   = (longint'(1) <<< 31) - 1;
    localparam longint I32_MIN   = -(longint'(1) <<< 31);
    localparam longint I16_MAX   = 32767;
    localparam longint I16_MIN   = -32768;

    // per-channel filter state
    logic signed [15:0] rate_prev [CHANNELS];
    logic signed [15:0] bias_est  [CHANNELS];
    logic signed [31:0] acc_q14   [CHANNELS];
    logic signed [31:0] err_q14   [CHANNELS];
    logic               primed    [CHANNELS];

    logic signed [15:0] angle_expected [$];
    int                 mismatch_n;
    int                 checked_n;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // advances one channel and returns its angle estimate
    function automatic logic signed [15:0] predict_angle(
        input logic               kind,
        input logic signed [15:0] ref_in,
        input logic signed [15:0] rate_in
    );
        int     ch;
        longint acc;
        longint err;
        longint delta;
        longint bias_next;
        ch = int'(kind);
        if (ch >= CHANNELS) ch = CHANNELS - 1;

        acc = clamp(longint'(acc_q14[ch])
                    + (longint'(rate_prev[ch]) - longint'(bias_est[ch])) * RATE_GAIN,
                    I32_MIN, I32_MAX);

        // first sample keeps the old error
        if (primed[ch])
            err_q14[ch] = 32'(clamp(acc - longint'(ref_in) * Q_ONE, I32_MIN, I32_MAX));
        else
            primed[ch] = 1'b1;
        err = longint'(err_q14[ch]);

        acc = clamp(acc - err / CORR_DIV, I32_MIN, I32_MAX);
        acc_q14[ch] = 32'(acc);

        delta     = (err * BIAS_NUM) / BIAS_DEN;
        bias_next = (longint'(bias_est[ch]) * Q_ONE + delta) / Q_ONE;
        bias_est[ch]  = 16'(clamp(bias_next, I16_MIN, I16_MAX));
        rate_prev[ch] = rate_in;

        return 16'(clamp(acc / Q_ONE, I16_MIN, I16_MAX));
    endfunction

    always @(posedge aclk) begin : monitor
        logic signed [15:0] want;
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                rate_prev[c] = '0;
                bias_est[c]  = '0;
                acc_q14[c]   = '0;
                err_q14[c]   = '0;
                primed[c]    = 1'b0;
            end
            angle_expected.delete();
            mismatch_n = 0;
            checked_n  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (angle_expected.size() == 0) begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display("unexpected angle estimate %0d, nothing pending",
                                 m_angle_estimate);
                end else begin
                    want = angle_expected.pop_front();
                    checked_n++;
                    if (m_angle_estimate !== want) begin
                        mismatch_n++;
                        if (mismatch_n <= 10)
                            $display("angle estimate %0d: expected %0d, got %0d",
                                     checked_n, want, m_angle_estimate);
                    end
                end
            end
            if (s_valid && s_ready)
                angle_expected.push_back(predict_angle(s_kind, s_reference_angle,
                                                       s_rate_sample));
        end
        mismatches <= mismatch_n;
        checked    <= checked_n;
        pending    <= angle_expected.size();
    end

endmodule

// ===== bench/gyro_bias_complementary_filter_tb.sv =====
`timescale 1ns / 1ps

module gyro_bias_complementary_filter_tb;

    localparam int ITEM_TARGET  = 1200;
    localparam int CYCLE_LIMIT  = 400000;  // slowest run stays well under this limit
    localparam int DRAIN_CYCLES = 40;      // idle margin after the last drain
    localparam int LONG_HOLD    = 300;     // output stall, far longer than the pipeline

    logic               aclk              = 1'b0;
    logic               aresetn           = 1'b0;
    logic               s_valid           = 1'b0;
    logic               s_ready;
    logic               s_kind            = 1'b0;
    logic signed [15:0] s_reference_angle = '0;
    logic signed [15:0] s_rate_sample     = '0;
    logic               m_valid;
    logic               m_ready           = 1'b0;
    logic signed [15:0] m_angle_estimate;

    int mismatches;
    int pending;
    int checked;

    int items_sent   = 0;
    int cycles       = 0;
    bit src_steady   = 1'b0;  // sender offers back to back
    bit sink_steady  = 1'b0;  // receiver never drops ready
    bit hold_request = 1'b0;  // asks the receiver for one long stall

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    gyro_bias_complementary_filter dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_reference_angle (s_reference_angle),
        .s_rate_sample     (s_rate_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_angle_estimate  (m_angle_estimate)
    );

    gbcf_angle_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_reference_angle (s_reference_angle),
        .s_rate_sample     (s_rate_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_angle_estimate  (m_angle_estimate),
        .mismatches        (mismatches),
        .pending           (pending),
        .checked           (checked)
    );

    // Offer one item after a random gap. Valid is only dropped when a gap
    // is taken, so back-to-back items never see a low/high pair in one step.
    task automatic offer(input logic k, input logic signed [15:0] r,
                         input logic signed [15:0] w);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_kind            <= k;
        s_reference_angle <= r;
        s_rate_sample     <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Stop offering until every predicted estimate has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] full_scale();
        return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    endfunction

    // Receiver: random ready gaps, plus one long stall on request so the
    // pipeline backs up and s_ready drops while the sender keeps offering.
    initial begin : sink
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                gap = LONG_HOLD;
                hold_request = 1'b0;
            end else begin
                gap = sink_steady ? 0 : $urandom_range(0, 10);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int   seg;
        int   len;
        int   base_r;
        int   base_w;
        int   jitter;
        bit   held;
        logic ch;
        logic signed [15:0] r;
        logic signed [15:0] w;
        held = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: first samples per channel, full-scale fields, same-channel
        // back-to-back items, alternating bit patterns.
        offer(1'b0, 16'sd100, 16'sd1000);       // roll first sample, no new error
        offer(1'b1, 16'sh8000, 16'sh8000);      // pitch first sample, negative full scale
        offer(1'b0, 16'sh7FFF, 16'sh7FFF);
        offer(1'b0, 16'sh7FFF, 16'sh7FFF);      // same channel again: hazard wait
        offer(1'b1, 16'sh7FFF, 16'sh7FFF);
        offer(1'b1, 16'sh8000, 16'sh7FFF);
        offer(1'b0, 16'sh8000, 16'sh8000);
        offer(1'b0, 16'sd0, 16'sd0);
        offer(1'b1, -16'sd1, -16'sd1);
        offer(1'b1, 16'sd0, 16'sd0);
        offer(1'b0, 16'sh5555, 16'shAAAA);
        offer(1'b1, 16'shAAAA, 16'sh5555);
        offer(1'b0, 16'sh7FFF, 16'sh8000);
        offer(1'b1, 16'sh8000, 16'sh7FFF);
        offer(1'b0, 16'sh8000, 16'sh7FFF);
        offer(1'b1, 16'sh7FFF, 16'sh8000);
        drain();

        while (items_sent < ITEM_TARGET) begin
            // one long output stall with the sender pushing flat out
            if (!held && items_sent > 400) begin
                held         = 1'b1;
                hold_request = 1'b1;
                src_steady   = 1'b1;
                repeat (60) offer(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
                src_steady = 1'b0;
                drain();
            end

            seg         = $urandom_range(0, 3);
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            case (seg)
                0: begin
                    // noise: anything on either channel
                    len = $urandom_range(8, 30);
                    repeat (len)
                        offer(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
                end
                1: begin
                    // tracking: steady reference and near-constant rate on both
                    // channels, so the bias estimate has something to lock on to
                    len    = $urandom_range(20, 80);
                    base_r = int'($signed(16'($urandom)));
                    base_w = $urandom_range(0, 4000);
                    base_w = base_w - 2000;
                    repeat (len) begin
                        jitter = $urandom_range(0, 64);
                        r = 16'(base_r + jitter - 32);
                        jitter = $urandom_range(0, 16);
                        w = 16'(base_w + jitter - 8);
                        offer(1'($urandom_range(0, 1)), r, w);
                    end
                end
                2: begin
                    // full-scale run on one channel: drives the accumulator and
                    // the output toward saturation, with a few stray items
                    len = $urandom_range(40, 150);
                    ch  = 1'($urandom_range(0, 1));
                    r   = full_scale();
                    w   = full_scale();
                    repeat (len) begin
                        if ($urandom_range(0, 7) == 0)
                            offer(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
                        else
                            offer(ch, r, w);
                    end
                end
                default: begin
                    // same-channel burst: every item waits on the write-back
                    len = $urandom_range(10, 30);
                    ch  = 1'($urandom_range(0, 1));
                    repeat (len) begin
                        jitter = $urandom_range(0, 8000);
                        r = 16'(jitter - 4000);
                        jitter = $urandom_range(0, 1000);
                        w = 16'(jitter - 500);
                        offer(ch, r, w);
                    end
                end
            endcase

            if ($urandom_range(0, 4) == 0) drain();
        end

        src_steady  = 1'b0;
        sink_steady = 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d items on both channels, %0d angle estimates compared,",
                 items_sent, checked);
        $display("with first samples, full-scale runs, same-channel bursts and a long stall.");
        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/gbcf_pkg.sv
design/gbcf_ram.sv
design/gbcf_core.sv
design/gyro_bias_complementary_filter.sv
bench/gbcf_angle_checker.sv
bench/gyro_bias_complementary_filter_tb.sv
